// ===== sv/vp8fh_pkg.sv =====
// shared types and constants of the vp8 frame header parser
package vp8fh_pkg;

    typedef enum logic [4:0] {
        PH_TAG,
        PH_KEYHDR,
        PH_COLOR,
        PH_SEG_EN,
        PH_SEG_MAP,
        PH_SEG_DATA,
        PH_SEG_ABS,
        PH_FEAT_FLAG,
        PH_FEAT_SKIP,
        PH_PROB_FLAG,
        PH_PROB_SKIP,
        PH_LF_SKIP,
        PH_LFD_EN,
        PH_LFD_UPD,
        PH_LFD_FLAG,
        PH_LFD_SKIP,
        PH_PART,
        PH_Q_YAC,
        PH_Q_FLAG,
        PH_Q_SKIP,
        PH_RF_GOLD,
        PH_RF_ALT,
        PH_TAIL,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_FINISH
    } ctl_state_t;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_SHORT     = 2'd1;
    localparam logic [1:0] STATUS_PART_SIZE = 2'd2;
    localparam logic [1:0] STATUS_BAD_SYNC  = 2'd3;

    localparam logic [7:0] SYNC_BYTE0 = 8'h9d;
    localparam logic [7:0] SYNC_BYTE1 = 8'h01;
    localparam logic [7:0] SYNC_BYTE2 = 8'h2a;
    localparam logic [5:0] DIM_HI_MASK = 6'h3f;

    localparam logic [3:0] FEAT_SKIP_EVEN = 4'd8;
    localparam logic [3:0] FEAT_SKIP_ODD  = 4'd7;
    localparam logic [3:0] PROB_SKIP_BITS = 4'd8;
    localparam logic [3:0] LF_SKIP_BITS   = 4'd10;
    localparam logic [3:0] LFD_SKIP_BITS  = 4'd7;
    localparam logic [3:0] PART_BITS      = 4'd2;
    localparam logic [3:0] Q_YAC_BITS     = 4'd7;
    localparam logic [3:0] Q_SKIP_BITS    = 4'd5;
    localparam logic [3:0] COLOR_BITS     = 4'd2;
    localparam logic [3:0] SEG_ABS_BITS   = 4'd1;
    localparam logic [3:0] TAIL_MIN_BITS  = 4'd1;

    localparam logic [3:0] FEAT_COUNT = 4'd8;
    localparam logic [3:0] PROB_COUNT = 4'd3;
    localparam logic [3:0] LFD_COUNT  = 4'd8;
    localparam logic [3:0] Q_COUNT    = 4'd5;

    localparam logic [5:0] KEY_TAG_LEN   = 6'd10;
    localparam logic [5:0] INTER_TAG_LEN = 6'd3;

    localparam logic [23:0] SIZE_MAX = 24'hffffff;

    typedef struct packed {
        logic       step;
        logic       bit_val;
        logic       load;
        phase_t     load_phase;
        logic [3:0] load_bits;
        logic       clear;
        logic       inter;
    } walk_ctl_t;

    typedef struct packed {
        phase_t     phase;
        logic [8:0] bits_read;
        logic       parse_done;
    } walk_stat_t;

endpackage

// ===== sv/vp8fh_bit_walk.sv =====
// header bit walker: one header bit per cycle while ctl.step is set, through the field phases
module vp8fh_bit_walk
    import vp8fh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  walk_ctl_t  ctl,
    output walk_stat_t stat
);

    phase_t     phase_reg, phase_next;
    logic [3:0] bits_left_reg, bits_left_next;
    logic [3:0] repeat_reg, repeat_next;
    logic [8:0] bits_read_reg, bits_read_next;
    logic       map_reg, map_next;
    logic       gold_reg, gold_next;
    logic       done_reg, done_next;

    logic [3:0] bl_dec;
    logic [3:0] rc_inc;
    logic       skip_end;
    logic       active;
    logic       b;
    logic       feat_nx, prob_nx, lfd_nx, q_nx, seg_after;

    assign bl_dec   = bits_left_reg - 4'd1;
    assign skip_end = (bl_dec == 4'd0);
    assign rc_inc   = repeat_reg + 4'd1;
    assign b        = ctl.bit_val;
    assign active   = ctl.step && (phase_reg >= PH_COLOR) && (phase_reg != PH_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TAG;
            bits_left_reg <= 4'd0;
            repeat_reg    <= 4'd0;
            bits_read_reg <= 9'd0;
            map_reg       <= 1'b0;
            gold_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            bits_left_reg <= bits_left_next;
            repeat_reg    <= repeat_next;
            bits_read_reg <= bits_read_next;
            map_reg       <= map_next;
            gold_reg      <= gold_next;
            done_reg      <= done_next;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        bits_left_next = bits_left_reg;
        repeat_next    = repeat_reg;
        bits_read_next = bits_read_reg;
        map_next       = map_reg;
        gold_next      = gold_reg;
        done_next      = done_reg;
        feat_nx        = 1'b0;
        prob_nx        = 1'b0;
        lfd_nx         = 1'b0;
        q_nx           = 1'b0;
        seg_after      = 1'b0;

        if (ctl.clear)
        begin
            phase_next     = PH_TAG;
            bits_left_next = 4'd0;
            repeat_next    = 4'd0;
            bits_read_next = 9'd0;
            map_next       = 1'b0;
            gold_next      = 1'b0;
            done_next      = 1'b0;
        end
        else if (ctl.load)
        begin
            phase_next     = ctl.load_phase;
            bits_left_next = ctl.load_bits;
        end
        else if (active)
        begin
            bits_read_next = bits_read_reg + 9'd1;
            case (phase_reg)
                PH_COLOR:
                begin
                    bits_left_next = bl_dec;
                    if (skip_end)
                    begin
                        phase_next     = PH_SEG_EN;
                        bits_left_next = 4'd0;
                    end
                end
                PH_SEG_EN:
                begin
                    phase_next     = b ? PH_SEG_MAP : PH_LF_SKIP;
                    bits_left_next = b ? 4'd0 : LF_SKIP_BITS;
                end
                PH_SEG_MAP:
                begin
                    map_next       = b;
                    phase_next     = PH_SEG_DATA;
                    bits_left_next = 4'd0;
                end
                PH_SEG_DATA:
                begin
                    if (b)
                    begin
                        phase_next     = PH_SEG_ABS;
                        bits_left_next = SEG_ABS_BITS;
                    end
                    else
                    begin
                        seg_after = 1'b1;
                    end
                end
                PH_SEG_ABS:
                begin
                    bits_left_next = bl_dec;
                    if (skip_end)
                    begin
                        repeat_next    = 4'd0;
                        phase_next     = PH_FEAT_FLAG;
                        bits_left_next = 4'd0;
                    end
                end
                PH_FEAT_FLAG:
                begin
                    if (b)
                    begin
                        phase_next     = PH_FEAT_SKIP;
                        bits_left_next = repeat_reg[0] ? FEAT_SKIP_ODD : FEAT_SKIP_EVEN;
                    end
                    else
                    begin
                        feat_nx = 1'b1;
                    end
                end
                PH_FEAT_SKIP:
                begin
                    bits_left_next = bl_dec;
                    feat_nx        = skip_end;
                end
                PH_PROB_FLAG:
                begin
                    if (b)
                    begin
                        phase_next     = PH_PROB_SKIP;
                        bits_left_next = PROB_SKIP_BITS;
                    end
                    else
                    begin
                        prob_nx = 1'b1;
                    end
                end
                PH_PROB_SKIP:
                begin
                    bits_left_next = bl_dec;
                    prob_nx        = skip_end;
                end
                PH_LF_SKIP:
                begin
                    bits_left_next = bl_dec;
                    if (skip_end)
                    begin
                        phase_next     = PH_LFD_EN;
                        bits_left_next = 4'd0;
                    end
                end
                PH_LFD_EN:
                begin
                    phase_next     = b ? PH_LFD_UPD : PH_PART;
                    bits_left_next = b ? 4'd0 : PART_BITS;
                end
                PH_LFD_UPD:
                begin
                    if (b)
                    begin
                        repeat_next    = 4'd0;
                        phase_next     = PH_LFD_FLAG;
                        bits_left_next = 4'd0;
                    end
                    else
                    begin
                        phase_next     = PH_PART;
                        bits_left_next = PART_BITS;
                    end
                end
                PH_LFD_FLAG:
                begin
                    if (b)
                    begin
                        phase_next     = PH_LFD_SKIP;
                        bits_left_next = LFD_SKIP_BITS;
                    end
                    else
                    begin
                        lfd_nx = 1'b1;
                    end
                end
                PH_LFD_SKIP:
                begin
                    bits_left_next = bl_dec;
                    lfd_nx         = skip_end;
                end
                PH_PART:
                begin
                    bits_left_next = bl_dec;
                    if (skip_end)
                    begin
                        phase_next     = PH_Q_YAC;
                        bits_left_next = Q_YAC_BITS;
                    end
                end
                PH_Q_YAC:
                begin
                    bits_left_next = bl_dec;
                    if (skip_end)
                    begin
                        repeat_next    = 4'd0;
                        phase_next     = PH_Q_FLAG;
                        bits_left_next = 4'd0;
                    end
                end
                PH_Q_FLAG:
                begin
                    if (b)
                    begin
                        phase_next     = PH_Q_SKIP;
                        bits_left_next = Q_SKIP_BITS;
                    end
                    else
                    begin
                        q_nx = 1'b1;
                    end
                end
                PH_Q_SKIP:
                begin
                    bits_left_next = bl_dec;
                    q_nx           = skip_end;
                end
                PH_RF_GOLD:
                begin
                    gold_next      = b;
                    phase_next     = PH_RF_ALT;
                    bits_left_next = 4'd0;
                end
                PH_RF_ALT:
                begin
                    // copy flags when not refreshed, sign bias, entropy, last
                    phase_next     = PH_TAIL;
                    bits_left_next = (gold_reg ? 4'd0 : 4'd2) + (b ? 4'd0 : 4'd2) + 4'd4;
                end
                PH_TAIL:
                begin
                    bits_left_next = bl_dec;
                    if (skip_end)
                    begin
                        done_next      = 1'b1;
                        phase_next     = PH_DONE;
                        bits_left_next = 4'd0;
                    end
                end
                default:
                begin
                    phase_next     = PH_DONE;
                    bits_left_next = 4'd0;
                end
            endcase

            if (feat_nx)
            begin
                repeat_next = rc_inc;
                if (rc_inc >= FEAT_COUNT)
                begin
                    seg_after = 1'b1;
                end
                else
                begin
                    phase_next     = PH_FEAT_FLAG;
                    bits_left_next = 4'd0;
                end
            end
            if (seg_after)
            begin
                if (map_next)
                begin
                    repeat_next    = 4'd0;
                    phase_next     = PH_PROB_FLAG;
                    bits_left_next = 4'd0;
                end
                else
                begin
                    phase_next     = PH_LF_SKIP;
                    bits_left_next = LF_SKIP_BITS;
                end
            end
            if (prob_nx)
            begin
                repeat_next    = rc_inc;
                phase_next     = (rc_inc >= PROB_COUNT) ? PH_LF_SKIP : PH_PROB_FLAG;
                bits_left_next = (rc_inc >= PROB_COUNT) ? LF_SKIP_BITS : 4'd0;
            end
            if (lfd_nx)
            begin
                repeat_next    = rc_inc;
                phase_next     = (rc_inc >= LFD_COUNT) ? PH_PART : PH_LFD_FLAG;
                bits_left_next = (rc_inc >= LFD_COUNT) ? PART_BITS : 4'd0;
            end
            if (q_nx)
            begin
                repeat_next = rc_inc;
                if (rc_inc < Q_COUNT)
                begin
                    phase_next     = PH_Q_FLAG;
                    bits_left_next = 4'd0;
                end
                else if (ctl.inter)
                begin
                    phase_next     = PH_RF_GOLD;
                    bits_left_next = 4'd0;
                end
                else
                begin
                    phase_next     = PH_TAIL;
                    bits_left_next = TAIL_MIN_BITS;
                end
            end
        end
    end

    assign stat.phase      = phase_reg;
    assign stat.bits_read  = bits_read_reg;
    assign stat.parse_done = done_reg;

endmodule

// ===== sv/vp8_frame_header_parser.sv =====
// vp8 frame header parser top level: byte intake, frame tag capture and result register
//
// input beats carry one frame byte each on s_tdata, with s_tlast on the final byte
// of the frame. one result beat per frame leaves on the m_ side after its last byte.
// frame tag and keyframe header bytes (first 3, or first 10 on a keyframe) are taken
// directly in the idle state. header bytes after that are shifted through the bit
// walker one bit per cycle, and the next byte can be taken while the last bit of
// the current one shifts. bytes past the end of the header are only counted once
// the walker is done, and are shifted like header bytes while it is still running.
// after the last byte the finish state forms the result and loads it into the
// output register, which raises m_tvalid.
// the result sits in an output register; the next frame's bytes are taken while it
// waits. if the receiver still holds the previous result when a new frame ends, the
// block waits with s_tready low until that result is taken.
// the byte count saturates at 2^FRAME_SIZE_BITS - 1.
// reset clears the control state and the kept width and height; no memory clearing.
module vp8_frame_header_parser
    import vp8fh_pkg::*;
#(
    parameter int FRAME_SIZE_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // frame_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], profile[3:2], frame_width[17:4], frame_height[31:18],
    // byte_total[55:32], header_bytes[61:56], zero[63:62]
    output logic [63:0] m_tdata,
    output logic        m_tuser    // key_frame
);

    localparam int CMP_W = (FRAME_SIZE_BITS > 24) ? FRAME_SIZE_BITS : 24;

    ctl_state_t state_reg, state_next;
    logic [2:0] bit_cnt_reg, bit_cnt_next;
    logic [7:0] shift_reg, shift_next;
    logic       last_reg, last_next;
    logic [FRAME_SIZE_BITS-1:0] count_reg, count_next;
    logic [7:0] tag0_reg, tag0_next;
    logic [7:0] tag1_reg, tag1_next;
    logic [7:0] tag2_reg, tag2_next;
    logic       sync_ok_reg, sync_ok_next;
    logic [7:0] wlo_reg, wlo_next;
    logic [5:0] whi_reg, whi_next;
    logic [7:0] hlo_reg, hlo_next;
    logic [5:0] hhi_reg, hhi_next;
    logic [13:0] kept_w_reg, kept_w_next;
    logic [13:0] kept_h_reg, kept_h_next;
    logic        m_valid_reg, m_valid_next;
    logic [63:0] out_data_reg, out_data_next;
    logic        out_key_reg, out_key_next;

    walk_ctl_t  wctl;
    walk_stat_t wstat;

    logic        in_fire;
    logic        count_full;
    logic        out_free;
    logic [CMP_W-1:0] n_ext;
    logic [18:0] part;
    logic        key;
    logic [1:0]  fin_status;
    logic        fin_upd;
    logic [6:0]  fin_ceil;
    logic [5:0]  fin_hdr;
    logic [13:0] fin_w, fin_h;
    logic [23:0] fin_size;

    vp8fh_bit_walk u_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (wctl),
        .stat  (wstat)
    );

    assign s_tready   = (state_reg == ST_IDLE)
                     || (state_reg == ST_SHIFT && bit_cnt_reg == 3'd7 && !last_reg);
    assign in_fire    = s_tvalid && s_tready;
    assign count_full = (count_reg == {FRAME_SIZE_BITS{1'b1}});
    assign out_free   = !m_valid_reg || m_tready;

    // frame result
    assign n_ext    = CMP_W'(count_reg);
    assign part     = {tag2_reg, tag1_reg, tag0_reg[7:5]};
    assign key      = ~tag0_reg[0];
    assign fin_ceil = 7'((10'(wstat.bits_read) + 10'd7) >> 3);
    assign fin_size = (n_ext > CMP_W'(SIZE_MAX)) ? SIZE_MAX : n_ext[23:0];

    always_comb
    begin
        fin_upd    = 1'b0;
        fin_status = STATUS_OK;
        if (n_ext < CMP_W'(3))
        begin
            fin_status = STATUS_SHORT;
        end
        else if (CMP_W'(part) > n_ext)
        begin
            fin_status = STATUS_PART_SIZE;
        end
        else if (key && n_ext < CMP_W'(10))
        begin
            fin_status = STATUS_SHORT;
        end
        else if (key && !sync_ok_reg)
        begin
            fin_status = STATUS_BAD_SYNC;
        end
        else
        begin
            fin_upd    = key;
            fin_status = wstat.parse_done ? STATUS_OK : STATUS_SHORT;
        end
        fin_hdr = (fin_status == STATUS_OK)
                ? 6'((key ? KEY_TAG_LEN : INTER_TAG_LEN) + 6'(fin_ceil)) : 6'd0;
        fin_w   = fin_upd ? {whi_reg & DIM_HI_MASK, wlo_reg} : kept_w_reg;
        fin_h   = fin_upd ? {hhi_reg & DIM_HI_MASK, hlo_reg} : kept_h_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= 3'd0;
            last_reg    <= 1'b0;
            count_reg   <= '0;
            kept_w_reg  <= 14'd0;
            kept_h_reg  <= 14'd0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            last_reg    <= last_next;
            count_reg   <= count_next;
            kept_w_reg  <= kept_w_next;
            kept_h_reg  <= kept_h_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg    <= shift_next;
        tag0_reg     <= tag0_next;
        tag1_reg     <= tag1_next;
        tag2_reg     <= tag2_next;
        sync_ok_reg  <= sync_ok_next;
        wlo_reg      <= wlo_next;
        whi_reg      <= whi_next;
        hlo_reg      <= hlo_next;
        hhi_reg      <= hhi_next;
        out_data_reg <= out_data_next;
        out_key_reg  <= out_key_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        bit_cnt_next  = bit_cnt_reg;
        shift_next    = shift_reg;
        last_next     = last_reg;
        count_next    = count_reg;
        tag0_next     = tag0_reg;
        tag1_next     = tag1_reg;
        tag2_next     = tag2_reg;
        sync_ok_next  = sync_ok_reg;
        wlo_next      = wlo_reg;
        whi_next      = whi_reg;
        hlo_next      = hlo_reg;
        hhi_next      = hhi_reg;
        kept_w_next   = kept_w_reg;
        kept_h_next   = kept_h_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        out_data_next = out_data_reg;
        out_key_next  = out_key_reg;

        wctl.step       = 1'b0;
        wctl.bit_val    = shift_reg[7];
        wctl.load       = 1'b0;
        wctl.load_phase = PH_TAG;
        wctl.load_bits  = 4'd0;
        wctl.clear      = 1'b0;
        wctl.inter      = tag0_reg[0];

        if (in_fire && !count_full)
        begin
            count_next = count_reg + FRAME_SIZE_BITS'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (wstat.phase == PH_TAG || wstat.phase == PH_KEYHDR)
                    begin
                        if (count_reg < FRAME_SIZE_BITS'(10))
                        begin
                            case (count_reg[3:0])
                                4'd0: tag0_next = s_tdata;
                                4'd1: tag1_next = s_tdata;
                                4'd2: tag2_next = s_tdata;
                                4'd3: sync_ok_next = (s_tdata == SYNC_BYTE0);
                                4'd4: sync_ok_next = sync_ok_reg && (s_tdata == SYNC_BYTE1);
                                4'd5: sync_ok_next = sync_ok_reg && (s_tdata == SYNC_BYTE2);
                                4'd6: wlo_next = s_tdata;
                                4'd7: whi_next = s_tdata[5:0];
                                4'd8: hlo_next = s_tdata;
                                4'd9: hhi_next = s_tdata[5:0];
                                default: ;
                            endcase
                        end
                        if (wstat.phase == PH_TAG && count_reg == FRAME_SIZE_BITS'(2))
                        begin
                            wctl.load       = 1'b1;
                            wctl.load_phase = tag0_reg[0] ? PH_SEG_EN : PH_KEYHDR;
                        end
                        else if (wstat.phase == PH_KEYHDR
                                 && count_reg >= FRAME_SIZE_BITS'(9))
                        begin
                            wctl.load       = 1'b1;
                            wctl.load_phase = PH_COLOR;
                            wctl.load_bits  = COLOR_BITS;
                        end
                        state_next = s_tlast ? ST_FINISH : ST_IDLE;
                    end
                    else if (wstat.phase == PH_DONE)
                    begin
                        state_next = s_tlast ? ST_FINISH : ST_IDLE;
                    end
                    else
                    begin
                        shift_next   = s_tdata;
                        last_next    = s_tlast;
                        bit_cnt_next = 3'd0;
                        state_next   = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT:
            begin
                wctl.step    = 1'b1;
                shift_next   = {shift_reg[6:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 3'd1;
                if (bit_cnt_reg == 3'd7)
                begin
                    if (in_fire)
                    begin
                        shift_next = s_tdata;
                        last_next  = s_tlast;
                    end
                    else if (last_reg)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    out_key_next  = key;
                    out_data_next = {2'b00, fin_hdr, fin_size, fin_h, fin_w,
                                     tag0_reg[2:1], fin_status};
                    kept_w_next   = fin_w;
                    kept_h_next   = fin_h;
                    wctl.clear    = 1'b1;
                    count_next    = '0;
                    last_next     = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_key_reg;

    a_shift_not_tag: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SHIFT |-> wstat.phase != PH_TAG && wstat.phase != PH_KEYHDR)
        else $error("header byte shifted while frame tag still open");

    a_bitcnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_SHIFT |-> bit_cnt_reg == 3'd0)
        else $error("bit counter left mid byte");

    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH && out_free |=> m_valid_reg && state_reg == ST_IDLE)
        else $error("frame result not loaded");

    a_err_no_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && out_data_reg[1:0] != STATUS_OK |-> out_data_reg[61:56] == 6'd0)
        else $error("header length on failed frame");

    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> count_reg != '0)
        else $error("byte count lost an accepted byte");

endmodule
